### design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Same-cycle implication check failed.");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Next-cycle implication check failed.");

`endif

### design/hpc_pkg.sv
// Package with the types, codes and constants of the hex prefix processor core.
package hpc_pkg;

    localparam int unsigned MEM_WORDS = 32768;
    localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

    typedef logic [MEM_AW-1:0] t_maddr;

    typedef enum logic [1:0] {
        OPN_WRITE = 2'd0,
        OPN_EXEC  = 2'd1,
        OPN_READ  = 2'd2,
        OPN_NONE  = 2'd3
    } t_operation;

    typedef enum logic [3:0] {
        IC_LDAM = 4'h0,
        IC_LDBM = 4'h1,
        IC_STAM = 4'h2,
        IC_LDAC = 4'h3,
        IC_LDBC = 4'h4,
        IC_LDAP = 4'h5,
        IC_LDAI = 4'h6,
        IC_LDBI = 4'h7,
        IC_STAI = 4'h8,
        IC_BR   = 4'h9,
        IC_BRZ  = 4'hA,
        IC_BRN  = 4'hB,
        IC_BRB  = 4'hC,
        IC_OPR  = 4'hD,
        IC_PFIX = 4'hE,
        IC_NFIX = 4'hF
    } t_icode;

    localparam logic [15:0] OPR_ADD    = 16'd0;
    localparam logic [15:0] OPR_SUB    = 16'd1;
    localparam logic [15:0] OPR_IN     = 16'd2;
    localparam logic [15:0] OPR_OUT    = 16'd3;
    localparam logic [15:0] NFIX_HIGH  = 16'hFF00;

    typedef enum logic [3:0] {
        UA_IDLE,
        UA_WRITE,
        UA_READ,
        UA_READ_WB,
        UA_FETCH,
        UA_DECODE,
        UA_LD_O_A,
        UA_LD_O_B,
        UA_LD_AO,
        UA_LD_BO,
        UA_WB_A,
        UA_WB_B,
        UA_ST_O,
        UA_ST_BO,
        UA_EXEC,
        UA_NOP
    } t_uaddr;

    typedef enum logic [2:0] {
        AS_ITEM,
        AS_PC,
        AS_O,
        AS_AO,
        AS_BO
    } t_asel;

    typedef enum logic [1:0] {
        DS_NONE,
        DS_A,
        DS_B,
        DS_RDV
    } t_dsel;

    typedef enum logic [1:0] {
        NX_WAIT,
        NX_GOTO,
        NX_DISP_OP,
        NX_DISP_CODE
    } t_nxt;

    typedef struct packed {
        logic   mem_rd;
        logic   mem_wr;
        t_asel  asel;
        logic   wd_a;
        t_dsel  dsel;
        logic   decode;
        logic   exec;
        logic   done;
        t_nxt   nxt;
        t_uaddr target;
    } t_uctl;

    typedef struct packed {
        logic [1:0]  operation;
        logic [14:0] word_address;
        logic [15:0] write_value;
        logic [15:0] input_value;
    } t_item;

    typedef struct packed {
        logic [15:0] program_counter;
        logic [15:0] acc_a;
        logic [15:0] acc_b;
        logic        output_valid;
        logic [15:0] output_word;
        logic [15:0] output_port;
        logic        input_taken;
        logic [15:0] input_port;
        logic [15:0] read_value;
    } t_result;

endpackage

### design/hpc_mem.sv
// Single-port word memory with registered read data.
module hpc_mem
    import hpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rd,
    input  logic        i_wr,
    input  t_maddr      i_addr,
    input  logic [15:0] i_wdata,
    output logic [15:0] o_rdata
);

    logic [15:0] r_mem [MEM_WORDS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/hpc_useq.sv
// Microcode sequencer: step counter, control store and dispatch logic.
module hpc_useq
    import hpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_operation,
    input  t_icode     i_code,
    output t_uctl      o_ctl,
    output logic       o_busy
);

    t_uaddr r_upc;
    t_uaddr n_upc;
    t_uctl  w_ctl;

    function automatic t_uctl uw(
        input logic   rd,
        input logic   wr,
        input t_asel  asel,
        input logic   wd_a,
        input t_dsel  dsel,
        input logic   dec,
        input logic   ex,
        input logic   dn,
        input t_nxt   nx,
        input t_uaddr tg
    );
        t_uctl c;
        c.mem_rd = rd;
        c.mem_wr = wr;
        c.asel   = asel;
        c.wd_a   = wd_a;
        c.dsel   = dsel;
        c.decode = dec;
        c.exec   = ex;
        c.done   = dn;
        c.nxt    = nx;
        c.target = tg;
        return c;
    endfunction

    always_comb begin
        case (r_upc)
            UA_IDLE:    w_ctl = uw(1'b0, 1'b0, AS_ITEM, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b0,
                               NX_DISP_OP, UA_IDLE);
            UA_WRITE:   w_ctl = uw(1'b0, 1'b1, AS_ITEM, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b1,
                               NX_GOTO, UA_IDLE);
            UA_READ:    w_ctl = uw(1'b1, 1'b0, AS_ITEM, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b0,
                               NX_GOTO, UA_READ_WB);
            UA_READ_WB: w_ctl = uw(1'b0, 1'b0, AS_ITEM, 1'b0, DS_RDV, 1'b0, 1'b0, 1'b1,
                               NX_GOTO, UA_IDLE);
            UA_FETCH:   w_ctl = uw(1'b1, 1'b0, AS_PC, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b0,
                               NX_GOTO, UA_DECODE);
            UA_DECODE:  w_ctl = uw(1'b0, 1'b0, AS_PC, 1'b0, DS_NONE, 1'b1, 1'b0, 1'b0,
                               NX_DISP_CODE, UA_IDLE);
            UA_LD_O_A:  w_ctl = uw(1'b1, 1'b0, AS_O, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b0,
                               NX_GOTO, UA_WB_A);
            UA_LD_O_B:  w_ctl = uw(1'b1, 1'b0, AS_O, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b0,
                               NX_GOTO, UA_WB_B);
            UA_LD_AO:   w_ctl = uw(1'b1, 1'b0, AS_AO, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b0,
                               NX_GOTO, UA_WB_A);
            UA_LD_BO:   w_ctl = uw(1'b1, 1'b0, AS_BO, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b0,
                               NX_GOTO, UA_WB_B);
            UA_WB_A:    w_ctl = uw(1'b0, 1'b0, AS_ITEM, 1'b0, DS_A, 1'b0, 1'b0, 1'b1,
                               NX_GOTO, UA_IDLE);
            UA_WB_B:    w_ctl = uw(1'b0, 1'b0, AS_ITEM, 1'b0, DS_B, 1'b0, 1'b0, 1'b1,
                               NX_GOTO, UA_IDLE);
            UA_ST_O:    w_ctl = uw(1'b0, 1'b1, AS_O, 1'b1, DS_NONE, 1'b0, 1'b0, 1'b1,
                               NX_GOTO, UA_IDLE);
            UA_ST_BO:   w_ctl = uw(1'b0, 1'b1, AS_BO, 1'b1, DS_NONE, 1'b0, 1'b0, 1'b1,
                               NX_GOTO, UA_IDLE);
            UA_EXEC:    w_ctl = uw(1'b0, 1'b0, AS_ITEM, 1'b0, DS_NONE, 1'b0, 1'b1, 1'b1,
                               NX_GOTO, UA_IDLE);
            UA_NOP:     w_ctl = uw(1'b0, 1'b0, AS_ITEM, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b1,
                               NX_GOTO, UA_IDLE);
            default:    w_ctl = uw(1'b0, 1'b0, AS_ITEM, 1'b0, DS_NONE, 1'b0, 1'b0, 1'b0,
                               NX_GOTO, UA_IDLE);
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        case (w_ctl.nxt)
            NX_GOTO: begin
                n_upc = w_ctl.target;
            end
            NX_DISP_OP: begin
                if (i_accept) begin
                    case (t_operation'(i_operation))
                        OPN_WRITE: n_upc = UA_WRITE;
                        OPN_EXEC:  n_upc = UA_FETCH;
                        OPN_READ:  n_upc = UA_READ;
                        default:   n_upc = UA_NOP;
                    endcase
                end
            end
            NX_DISP_CODE: begin
                case (i_code)
                    IC_LDAM: n_upc = UA_LD_O_A;
                    IC_LDBM: n_upc = UA_LD_O_B;
                    IC_STAM: n_upc = UA_ST_O;
                    IC_LDAI: n_upc = UA_LD_AO;
                    IC_LDBI: n_upc = UA_LD_BO;
                    IC_STAI: n_upc = UA_ST_BO;
                    default: n_upc = UA_EXEC;
                endcase
            end
            default: begin
                n_upc = r_upc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl  = w_ctl;
    assign o_busy = (r_upc != UA_IDLE);

endmodule

### design/hex_prefix_cpu_core_top.sv
// Top level of the hex prefix processor core: register datapath, sequencer and memory.
// An item is taken when i_start is high and o_busy is low; its result appears on o_result
// for one cycle with o_done, and o_busy is already low in that cycle, so the next item can
// start at once. After acceptance a memory write passes the write step, an unknown
// operation a no-op step, a memory read a read and a writeback step, and an executed
// instruction a fetch and a decode step, then an execute or store step, or a read and a
// writeback step when it loads a data word, as the single memory port serves each in turn.
module hex_prefix_cpu_core_top
    import hpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    t_uctl       w_ctl;
    logic        w_accept;
    logic [15:0] w_rdata;
    logic [7:0]  w_byte;
    t_icode      w_code;
    t_maddr      w_maddr;
    logic [15:0] w_wdata;
    logic [15:0] w_sum_ao;
    logic [15:0] w_sum_bo;

    t_item       r_item,     n_item;
    logic [15:0] r_pc,       n_pc;
    logic [15:0] r_a,        n_a;
    logic [15:0] r_b,        n_b;
    logic [15:0] r_operand,  n_operand;
    logic [15:0] r_o,        n_o;
    t_icode      r_code,     n_code;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_word, n_out_word;
    logic [15:0] r_out_port, n_out_port;
    logic        r_in_taken, n_in_taken;
    logic [15:0] r_in_port,  n_in_port;
    logic [15:0] r_rdv,      n_rdv;
    logic        r_done;

    assign w_accept = i_start && !o_busy;

    hpc_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_operation (i_item.operation),
        .i_code      (w_code),
        .o_ctl       (w_ctl),
        .o_busy      (o_busy)
    );

    assign w_sum_ao = r_a + r_o;
    assign w_sum_bo = r_b + r_o;

    always_comb begin
        case (w_ctl.asel)
            AS_ITEM: w_maddr = r_item.word_address[MEM_AW-1:0];
            AS_PC:   w_maddr = r_pc[MEM_AW:1];
            AS_O:    w_maddr = r_o[MEM_AW-1:0];
            AS_AO:   w_maddr = w_sum_ao[MEM_AW-1:0];
            AS_BO:   w_maddr = w_sum_bo[MEM_AW-1:0];
            default: w_maddr = r_item.word_address[MEM_AW-1:0];
        endcase
    end

    assign w_wdata = w_ctl.wd_a ? r_a : r_item.write_value;

    hpc_mem u_mem (
        .i_clk   (i_clk),
        .i_rd    (w_ctl.mem_rd),
        .i_wr    (w_ctl.mem_wr),
        .i_addr  (w_maddr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_byte = r_pc[0] ? w_rdata[15:8] : w_rdata[7:0];
    assign w_code = t_icode'(w_byte[7:4]);

    always_comb begin
        n_item      = r_item;
        n_pc        = r_pc;
        n_a         = r_a;
        n_b         = r_b;
        n_operand   = r_operand;
        n_o         = r_o;
        n_code      = r_code;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_out_port  = r_out_port;
        n_in_taken  = r_in_taken;
        n_in_port   = r_in_port;
        n_rdv       = r_rdv;

        if (w_accept) begin
            n_item      = i_item;
            n_out_valid = 1'b0;
            n_out_word  = '0;
            n_out_port  = '0;
            n_in_taken  = 1'b0;
            n_in_port   = '0;
            n_rdv       = '0;
        end

        if (w_ctl.decode) begin
            n_code    = w_code;
            n_o       = r_operand | {12'd0, w_byte[3:0]};
            n_operand = '0;
            n_pc      = r_pc + 16'd1;
        end

        case (w_ctl.dsel)
            DS_A:    n_a   = w_rdata;
            DS_B:    n_b   = w_rdata;
            DS_RDV:  n_rdv = w_rdata;
            default: ;
        endcase

        if (w_ctl.exec) begin
            case (r_code)
                IC_LDAC: n_a = r_o;
                IC_LDBC: n_b = r_o;
                IC_LDAP: n_a = r_pc + r_o;
                IC_BR:   n_pc = r_pc + r_o;
                IC_BRZ: begin
                    if (r_a == 16'd0) begin
                        n_pc = r_pc + r_o;
                    end
                end
                IC_BRN: begin
                    if (r_a[15]) begin
                        n_pc = r_pc + r_o;
                    end
                end
                IC_BRB:  n_pc = w_sum_bo;
                IC_OPR: begin
                    case (r_o)
                        OPR_ADD: n_a = r_a + r_b;
                        OPR_SUB: n_a = r_a - r_b;
                        OPR_IN: begin
                            n_in_taken = 1'b1;
                            n_in_port  = r_a;
                            n_a        = r_item.input_value;
                        end
                        OPR_OUT: begin
                            n_out_valid = 1'b1;
                            n_out_word  = r_a;
                            n_out_port  = r_b;
                        end
                        default: n_operand = r_o;
                    endcase
                end
                IC_PFIX: n_operand = {r_o[11:0], 4'd0};
                IC_NFIX: n_operand = NFIX_HIGH | {r_o[11:0], 4'd0};
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_operand   <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_taken  <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_a         <= n_a;
            r_b         <= n_b;
            r_operand   <= n_operand;
            r_done      <= w_ctl.done;
            r_out_valid <= n_out_valid;
            r_in_taken  <= n_in_taken;
        end
        r_item     <= n_item;
        r_o        <= n_o;
        r_code     <= n_code;
        r_out_word <= n_out_word;
        r_out_port <= n_out_port;
        r_in_port  <= n_in_port;
        r_rdv      <= n_rdv;
    end

    assign o_done                   = r_done;
    assign o_result.program_counter = r_pc;
    assign o_result.acc_a           = r_a;
    assign o_result.acc_b           = r_b;
    assign o_result.output_valid    = r_out_valid;
    assign o_result.output_word     = r_out_word;
    assign o_result.output_port     = r_out_port;
    assign o_result.input_taken     = r_in_taken;
    assign o_result.input_port      = r_in_port;
    assign o_result.read_value      = r_rdv;

endmodule

### design/hpc_checker.sv
// Port-level checker for the hex prefix processor core and its bind statement.
`include "assert_macros.svh"

module hpc_checker
    import hpc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input logic    o_done,
    input t_result o_result
);

    `ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, o_done, !o_busy)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_IMPL(a_io_exclusive, i_clk, i_rst_n, o_done, !(o_result.output_valid && o_result.input_taken))

endmodule

bind hex_prefix_cpu_core_top hpc_checker u_hpc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

### tb/sv/hpc_result_checker.sv
// Checker that predicts the result of every item of the hex prefix processor core and compares it.
module hpc_result_checker
    import hpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_done,
    input  t_result i_result,
    output int      o_errors,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] core_mem [MEM_WORDS];
    bit          mem_known [MEM_WORDS];
    logic [15:0] core_pc;
    logic [15:0] core_a;
    logic [15:0] core_b;
    logic [15:0] core_opnd;
    t_result     predicted_states [$];
    int          error_count = 0;
    int          result_index = 0;

    assign o_errors = error_count;

    function automatic int word_slot(logic [15:0] addr);
        return int'(addr) % MEM_WORDS;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t, result %0d: %s", $realtime, result_index, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s is %h, expected %h", field, got, want));
    endtask

    task automatic execute_item(input t_item it, output t_result res);
        logic [15:0] word_v;
        logic [7:0]  ibyte;
        logic [15:0] opnd;
        res = '0;
        case (t_operation'(it.operation))
            OPN_WRITE: begin
                core_mem[word_slot({1'b0, it.word_address})]  = it.write_value;
                mem_known[word_slot({1'b0, it.word_address})] = 1'b1;
            end
            OPN_READ:  res.read_value = core_mem[word_slot({1'b0, it.word_address})];
            OPN_EXEC: begin
                word_v    = core_mem[word_slot(core_pc >> 1)];
                ibyte     = core_pc[0] ? word_v[15:8] : word_v[7:0];
                core_pc   = core_pc + 16'd1;
                opnd      = core_opnd | {12'h000, ibyte[3:0]};
                core_opnd = '0;
                case (t_icode'(ibyte[7:4]))
                    IC_LDAM: core_a = core_mem[word_slot(opnd)];
                    IC_LDBM: core_b = core_mem[word_slot(opnd)];
                    IC_STAM: begin
                        core_mem[word_slot(opnd)]  = core_a;
                        mem_known[word_slot(opnd)] = 1'b1;
                    end
                    IC_LDAC: core_a = opnd;
                    IC_LDBC: core_b = opnd;
                    IC_LDAP: core_a = core_pc + opnd;
                    IC_LDAI: core_a = core_mem[word_slot(core_a + opnd)];
                    IC_LDBI: core_b = core_mem[word_slot(core_b + opnd)];
                    IC_STAI: begin
                        core_mem[word_slot(core_b + opnd)]  = core_a;
                        mem_known[word_slot(core_b + opnd)] = 1'b1;
                    end
                    IC_BR:   core_pc = core_pc + opnd;
                    IC_BRZ:  if (core_a == 16'h0000) core_pc = core_pc + opnd;
                    IC_BRN:  if (core_a[15]) core_pc = core_pc + opnd;
                    IC_BRB:  core_pc = core_b + opnd;
                    IC_OPR: begin
                        if (opnd == OPR_ADD) begin
                            core_a = core_a + core_b;
                        end else if (opnd == OPR_SUB) begin
                            core_a = core_a - core_b;
                        end else if (opnd == OPR_IN) begin
                            res.input_taken = 1'b1;
                            res.input_port  = core_a;
                            core_a          = it.input_value;
                        end else if (opnd == OPR_OUT) begin
                            res.output_valid = 1'b1;
                            res.output_word  = core_a;
                            res.output_port  = core_b;
                        end else begin
                            // An unknown operate code keeps its operand in the operand register instead of clearing it.
                            core_opnd = opnd;
                        end
                    end
                    IC_PFIX: core_opnd = opnd << 4;
                    IC_NFIX: core_opnd = NFIX_HIGH | (opnd << 4);
                endcase
            end
            default: ;
        endcase
        res.program_counter = core_pc;
        res.acc_a           = core_a;
        res.acc_b           = core_b;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            core_pc   = '0;
            core_a    = '0;
            core_b    = '0;
            core_opnd = '0;
            predicted_states.delete();
        end else begin
            if (i_done) begin
                if (predicted_states.size() == 0) begin
                    report_error("result with no item outstanding");
                end else begin
                    want = predicted_states.pop_front();
                    check_field("program_counter", i_result.program_counter,
                                want.program_counter);
                    check_field("acc_a", i_result.acc_a, want.acc_a);
                    check_field("acc_b", i_result.acc_b, want.acc_b);
                    check_field("output_valid", 16'(i_result.output_valid),
                                16'(want.output_valid));
                    check_field("output_word", i_result.output_word, want.output_word);
                    check_field("output_port", i_result.output_port, want.output_port);
                    check_field("input_taken", 16'(i_result.input_taken),
                                16'(want.input_taken));
                    check_field("input_port", i_result.input_port, want.input_port);
                    check_field("read_value", i_result.read_value, want.read_value);
                end
                result_index++;
            end
            if (i_start && !i_busy) begin
                execute_item(i_item, want);
                predicted_states.push_back(want);
            end
        end
        o_pending <= predicted_states.size();
    end

endmodule

### tb/sv/hex_prefix_cpu_core_top_test.sv
// Testbench top of the hex prefix processor core: stimulus, clock, reset and verdict.
module hex_prefix_cpu_core_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hpc_pkg::*;

    localparam int         RANDOM_ITEMS = 1750;
    localparam longint     CYCLE_LIMIT  = 1_000_000;
    localparam logic [3:0] OPR_UNKNOWN  = 4'd7;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    t_item       item    = '0;
    logic        busy;
    logic        done;
    t_result     result;
    int          errors;
    int          pending;
    logic [15:0] last_pc = '0;
    bit          no_gaps = 1'b0;
    int          sent    = 0;
    longint      cycles  = 0;

    always #5 clk = ~clk;

    hex_prefix_cpu_core_top dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_start  (start),
        .i_item   (item),
        .o_busy   (busy),
        .o_done   (done),
        .o_result (result)
    );

    hpc_result_checker result_check (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (item),
        .i_done    (done),
        .i_result  (result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always @(posedge clk) begin
        if (done === 1'b1)
            last_pc <= result.program_counter;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_item make_item(input t_operation op, input logic [14:0] addr,
                                        input logic [15:0] wdata);
        t_item it;
        it.operation    = op;
        it.word_address = addr;
        it.write_value  = wdata;
        it.input_value  = 16'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] program_byte();
        int     sel;
        t_icode code;
        logic [3:0] nib;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            code = IC_OPR;
        else if (sel < 35)
            code = IC_PFIX;
        else if (sel < 42)
            code = IC_NFIX;
        else
            code = t_icode'(4'($urandom_range(0, 15)));
        nib = 4'($urandom);
        if (code == IC_OPR && $urandom_range(0, 3) != 0)
            nib = 4'($urandom_range(0, 3));
        return {code, nib};
    endfunction

    task automatic send(input t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy !== 1'b0);
        sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Before each instruction, the fetch word and any data word it loads are written
    // if they never were.
    task automatic run_exec(input t_item it);
        logic [15:0] word_v;
        logic [7:0]  ibyte;
        logic [15:0] opnd;
        logic [15:0] daddr;
        t_maddr      slot;
        bit          loads;
        wait_drained();
        slot = result_check.core_pc[MEM_AW:1];
        if (!result_check.mem_known[slot]) begin
            send(make_item(OPN_WRITE, slot, {program_byte(), program_byte()}));
            wait_drained();
        end
        word_v = result_check.core_mem[slot];
        ibyte  = result_check.core_pc[0] ? word_v[15:8] : word_v[7:0];
        opnd   = result_check.core_opnd | {12'h000, ibyte[3:0]};
        loads  = 1'b1;
        case (t_icode'(ibyte[7:4]))
            IC_LDAM, IC_LDBM: daddr = opnd;
            IC_LDAI: daddr = result_check.core_a + opnd;
            IC_LDBI: daddr = result_check.core_b + opnd;
            default: begin
                daddr = '0;
                loads = 1'b0;
            end
        endcase
        slot = daddr[MEM_AW-1:0];
        if (loads && !result_check.mem_known[slot]) begin
            send(make_item(OPN_WRITE, slot, 16'($urandom)));
            wait_drained();
        end
        send(it);
    endtask

    task automatic send_exec();
        run_exec(make_item(OPN_EXEC, 15'($urandom), 16'($urandom)));
    endtask

    task automatic send_read(input logic [14:0] addr);
        wait_drained();
        if (!result_check.mem_known[addr])
            send(make_item(OPN_WRITE, addr, 16'($urandom)));
        send(make_item(OPN_READ, addr, 16'($urandom)));
    endtask

    initial begin
        logic [7:0]  demo [14];
        logic [15:0] base;
        t_item       it;
        int          n_words;
        int          kind;
        int          first_random;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        no_gaps  = 1'b0;
        demo[0]  = {IC_NFIX, 4'hF};
        demo[1]  = {IC_LDAC, 4'hF};
        demo[2]  = {IC_OPR, OPR_OUT[3:0]};
        demo[3]  = {IC_LDBC, 4'h1};
        demo[4]  = {IC_OPR, OPR_ADD[3:0]};
        demo[5]  = {IC_OPR, OPR_SUB[3:0]};
        demo[6]  = {IC_OPR, OPR_IN[3:0]};
        demo[7]  = {IC_BRN, 4'h1};
        demo[8]  = {IC_LDAM, 4'h0};
        demo[9]  = {IC_BRZ, 4'h1};
        demo[10] = {IC_OPR, OPR_UNKNOWN};
        demo[11] = {IC_LDAI, 4'hF};
        demo[12] = {IC_BRB, 4'h0};
        demo[13] = {IC_BR, 4'h0};
        for (int w = 0; w < 7; w++)
            send(make_item(OPN_WRITE, 15'(w), {demo[2 * w + 1], demo[2 * w]}));
        // The loaded input has bit 15 set, so the indexed load past it wraps around memory.
        for (int k = 0; k < 12; k++) begin
            it = make_item(OPN_EXEC, 15'($urandom), 16'($urandom));
            it.input_value = 16'h8000;
            run_exec(it);
        end
        send(make_item(OPN_READ, 15'h0000, 16'($urandom)));
        send(make_item(OPN_WRITE, 15'h7FFF, 16'hFFFF));
        send(make_item(OPN_READ, 15'h7FFF, 16'($urandom)));
        send(make_item(OPN_NONE, 15'($urandom), 16'($urandom)));

        first_random = sent;
        while (sent < first_random + RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 99);
            if (kind < 60) begin
                // Place a short program right at the current fetch point and run it.
                wait_drained();
                base    = last_pc >> 1;
                n_words = $urandom_range(1, 4);
                for (int w = 0; w < n_words; w++)
                    send(make_item(OPN_WRITE, 15'((int'(base) + w) % MEM_WORDS),
                                   {program_byte(), program_byte()}));
                repeat (2 * n_words + $urandom_range(0, 2)) send_exec();
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 8)) send_exec();
            end else begin
                case ($urandom_range(0, 2))
                    0: send(make_item(OPN_WRITE, 15'($urandom), 16'($urandom)));
                    1: send_read(15'($urandom));
                    default: send(make_item(OPN_NONE, 15'($urandom), 16'($urandom)));
                endcase
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
